// ===== src/cdiv_pkg.sv =====
// cdiv_pkg: shared widths, status codes and channel types for the complex divider
// no dependencies; imported by cdiv_long_div and complex_divide
`default_nettype none

package cdiv_pkg;

   // fixed point format of all operands and results
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   // fraction bits of the ratio of the smaller to the larger divisor part
   localparam int RATIO_BITS = 30;
   localparam int RAT_STEPS  = RATIO_BITS + 1;
   // width of intermediate products and scaled sums
   localparam int PROD_W     = 64;
   // magnitudes of the scaled numerator and denominator stay below 2^63
   localparam int MAG_W      = PROD_W - 1;
   // dividend of the long division is the magnitude with fraction bits appended
   localparam int NUM_W      = MAG_W + FRAC_BITS;
   // quotient bits produced, one above the result width to catch overflow
   localparam int QUO_W      = DATA_W + 1;
   localparam int HI_W       = NUM_W - QUO_W;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_SAT  = 2'd1,
      STAT_ZERO = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] num_re;
      logic signed [DATA_W-1:0] num_im;
      logic signed [DATA_W-1:0] den_re;
      logic signed [DATA_W-1:0] den_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quot_re;
      logic signed [DATA_W-1:0] quot_im;
      status_type               status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/cdiv_long_div.sv =====
// cdiv_long_div: pipelined restoring divider, one quotient bit per stage
// depends on cdiv_pkg for widths
`default_nettype none

module cdiv_long_div
   import cdiv_pkg::*;
(
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [MAG_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);

   logic [MAG_W-1:0] rem_ff [QUO_W+1];
   logic [MAG_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] lo_ff  [QUO_W+1];
   logic [QUO_W-1:0] q_ff   [QUO_W+1];
   logic             ovf_ff [QUO_W+1];

   logic [HI_W-1:0]  hi;
   logic             ovf_in;

   // quotient does not fit in QUO_W bits when the leading part reaches the divisor
   assign hi     = num[NUM_W-1:QUO_W];
   assign ovf_in = MAG_W'(hi) >= den;

   // entry stage
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= ovf_in ? '0 : MAG_W'(hi);
         den_ff[0] <= den;
         lo_ff[0]  <= num[QUO_W-1:0];
         q_ff[0]   <= '0;
         ovf_ff[0] <= ovf_in;
      end
   end

   // one stage per quotient bit, most significant first
   for (genvar s = 1; s <= QUO_W; s++) begin : g_step
      localparam int K = QUO_W - s;
      logic [MAG_W:0]   trial;
      logic [MAG_W:0]   diff;
      logic             fit;
      logic [QUO_W-1:0] q_in;

      assign trial = {rem_ff[s-1], lo_ff[s-1][K]};
      assign diff  = trial - {1'b0, den_ff[s-1]};
      assign fit   = trial >= {1'b0, den_ff[s-1]};

      always_comb begin
         q_in    = q_ff[s-1];
         q_in[K] = fit;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= fit ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            den_ff[s] <= den_ff[s-1];
            lo_ff[s]  <= lo_ff[s-1];
            q_ff[s]   <= q_in;
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign quo = q_ff[QUO_W];
   assign ovf = ovf_ff[QUO_W];

endmodule

`default_nettype wire

// ===== src/complex_divide.sv =====
// complex_divide: complex quotient by Smith's scaling method, signed fixed point
// depends on cdiv_pkg and cdiv_long_div
//
//   channel  ports                          carries
//   request  req_valid req_stall req_data   numerator and divisor, req_type
//   result   rsp_valid rsp_stall rsp_data   quotient and status, rsp_type
//
// one request per cycle while no held result stalls the pipeline; it has RAT_STEPS + QUO_W + 6 register stages (70),
// mostly in the bit-per-stage ratio divider and the two bit-per-stage long dividers
// synchronous reset clears only the valid bits; no clearing pass
// a held result freezes the whole pipeline, so req_stall follows rsp_stall
// while the output register is full
`default_nettype none

module complex_divide
   import cdiv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic                     sel_re;
      logic                     rneg;
      logic                     sbit;
      logic signed [DATA_W-1:0] big;
      logic signed [DATA_W-1:0] small_part;
      logic signed [DATA_W-1:0] ar;
      logic signed [DATA_W-1:0] ai;
      logic [DATA_W-1:0]        bmag;
      logic [DATA_W-1:0]        rem;
      logic [RATIO_BITS:0]      rq;
   } rat_type;

   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic                     sel_re;
      logic signed [DATA_W-1:0] big;
      logic signed [DATA_W-1:0] ar;
      logic signed [DATA_W-1:0] ai;
      logic signed [PROD_W-1:0] rs;
      logic signed [PROD_W-1:0] rar;
      logic signed [PROD_W-1:0] rai;
   } mul_type;

   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic signed [PROD_W-1:0] d;
      logic signed [PROD_W-1:0] p;
      logic signed [PROD_W-1:0] q;
   } add_type;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic             negp;
      logic             negq;
      logic [MAG_W-1:0] pmag;
      logic [MAG_W-1:0] qmag;
      logic [MAG_W-1:0] dmag;
   } mag_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic negp;
      logic negq;
   } side_type;

   logic     adv;
   rat_type  rat_ff [RAT_STEPS+1];
   rat_type  rat0_in;
   mul_type  mul_ff;
   mul_type  mul_in;
   add_type  add_ff;
   add_type  add_in;
   mag_type  mag_ff;
   mag_type  mag_in;
   side_type side_ff [QUO_W+1];
   rsp_type  rsp_data_ff;
   rsp_type  rsp_data_in;
   logic     rsp_valid_ff;

   logic [QUO_W-1:0] quo_p;
   logic [QUO_W-1:0] quo_q;
   logic             ovf_p;
   logic             ovf_q;

   // pipeline moves whenever the output register can take a result
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // divisor part magnitudes and choice of the larger part
   always_comb begin
      logic [DATA_W-1:0] mre;
      logic [DATA_W-1:0] mim;
      logic [DATA_W-1:0] smag;
      mre = req_data.den_re[DATA_W-1] ? DATA_W'(-req_data.den_re) : req_data.den_re;
      mim = req_data.den_im[DATA_W-1] ? DATA_W'(-req_data.den_im) : req_data.den_im;
      rat0_in            = '0;
      rat0_in.valid      = req_valid;
      rat0_in.zero       = (req_data.den_re == '0) && (req_data.den_im == '0);
      rat0_in.sel_re     = mre >= mim;
      rat0_in.big        = rat0_in.sel_re ? req_data.den_re : req_data.den_im;
      rat0_in.small_part = rat0_in.sel_re ? req_data.den_im : req_data.den_re;
      rat0_in.bmag       = rat0_in.sel_re ? mre : mim;
      smag               = rat0_in.sel_re ? mim : mre;
      rat0_in.rneg       = rat0_in.big[DATA_W-1] ^ rat0_in.small_part[DATA_W-1];
      rat0_in.ar         = req_data.num_re;
      rat0_in.ai         = req_data.num_im;
      rat0_in.sbit       = smag[0];
      rat0_in.rem        = smag >> 1;
      rat0_in.rq         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rat_ff[0].valid <= 1'b0;
      end else if (adv) begin
         rat_ff[0] <= rat0_in;
      end
   end

   // ratio divider: one bit of small/big per stage
   for (genvar j = 1; j <= RAT_STEPS; j++) begin : g_ratio
      localparam int K = RAT_STEPS - j;
      logic [DATA_W:0] trial;
      logic            fit;
      rat_type         nxt;

      assign trial = {rat_ff[j-1].rem, (j == 1) ? rat_ff[j-1].sbit : 1'b0};
      assign fit   = trial >= {1'b0, rat_ff[j-1].bmag};

      always_comb begin
         logic [DATA_W:0] diff;
         diff      = trial - {1'b0, rat_ff[j-1].bmag};
         nxt       = rat_ff[j-1];
         nxt.rem   = fit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         nxt.rq[K] = fit;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rat_ff[j].valid <= 1'b0;
         end else if (adv) begin
            rat_ff[j] <= nxt;
         end
      end
   end

   // signed ratio times divisor and numerator parts
   always_comb begin
      logic signed [DATA_W:0]   r;
      logic signed [DATA_W:0]   rmag;
      logic signed [PROD_W:0]   prs;
      logic signed [PROD_W:0]   prar;
      logic signed [PROD_W:0]   prai;
      rmag = $signed({2'b00, rat_ff[RAT_STEPS].rq});
      r    = rat_ff[RAT_STEPS].rneg ? -rmag : rmag;
      prs  = (PROD_W+1)'(r) * (PROD_W+1)'(rat_ff[RAT_STEPS].small_part);
      prar = (PROD_W+1)'(r) * (PROD_W+1)'(rat_ff[RAT_STEPS].ar);
      prai = (PROD_W+1)'(r) * (PROD_W+1)'(rat_ff[RAT_STEPS].ai);
      mul_in.valid  = rat_ff[RAT_STEPS].valid;
      mul_in.zero   = rat_ff[RAT_STEPS].zero;
      mul_in.sel_re = rat_ff[RAT_STEPS].sel_re;
      mul_in.big    = rat_ff[RAT_STEPS].big;
      mul_in.ar     = rat_ff[RAT_STEPS].ar;
      mul_in.ai     = rat_ff[RAT_STEPS].ai;
      mul_in.rs     = prs[PROD_W-1:0];
      mul_in.rar    = prar[PROD_W-1:0];
      mul_in.rai    = prai[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid <= 1'b0;
      end else if (adv) begin
         mul_ff <= mul_in;
      end
   end

   // scaled denominator and the two scaled numerators
   always_comb begin
      logic signed [PROD_W-1:0] bsc;
      logic signed [PROD_W-1:0] arsc;
      logic signed [PROD_W-1:0] aisc;
      bsc  = PROD_W'(mul_ff.big) <<< RATIO_BITS;
      arsc = PROD_W'(mul_ff.ar) <<< RATIO_BITS;
      aisc = PROD_W'(mul_ff.ai) <<< RATIO_BITS;
      add_in.valid = mul_ff.valid;
      add_in.zero  = mul_ff.zero;
      add_in.d     = bsc + mul_ff.rs;
      if (mul_ff.sel_re) begin
         add_in.p = arsc + mul_ff.rai;
         add_in.q = aisc - mul_ff.rar;
      end else begin
         add_in.p = mul_ff.rar + aisc;
         add_in.q = mul_ff.rai - arsc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_ff.valid <= 1'b0;
      end else if (adv) begin
         add_ff <= add_in;
      end
   end

   // sign and magnitude split for the long divisions
   always_comb begin
      logic [PROD_W-1:0] pa;
      logic [PROD_W-1:0] qa;
      logic [PROD_W-1:0] da;
      pa = add_ff.p[PROD_W-1] ? -add_ff.p : add_ff.p;
      qa = add_ff.q[PROD_W-1] ? -add_ff.q : add_ff.q;
      da = add_ff.d[PROD_W-1] ? -add_ff.d : add_ff.d;
      mag_in.valid = add_ff.valid;
      mag_in.zero  = add_ff.zero;
      mag_in.negp  = add_ff.p[PROD_W-1] ^ add_ff.d[PROD_W-1];
      mag_in.negq  = add_ff.q[PROD_W-1] ^ add_ff.d[PROD_W-1];
      mag_in.pmag  = pa[MAG_W-1:0];
      mag_in.qmag  = qa[MAG_W-1:0];
      mag_in.dmag  = da[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff.valid <= 1'b0;
      end else if (adv) begin
         mag_ff <= mag_in;
      end
   end

   // real and imaginary long divisions
   cdiv_long_div u_div_re (
      .clock (clock),
      .adv   (adv),
      .num   ({mag_ff.pmag, FRAC_BITS'(0)}),
      .den   (mag_ff.dmag),
      .quo   (quo_p),
      .ovf   (ovf_p)
   );

   cdiv_long_div u_div_im (
      .clock (clock),
      .adv   (adv),
      .num   ({mag_ff.qmag, FRAC_BITS'(0)}),
      .den   (mag_ff.dmag),
      .quo   (quo_q),
      .ovf   (ovf_q)
   );

   // control bits alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].valid <= 1'b0;
      end else if (adv) begin
         side_ff[0] <= '{valid: mag_ff.valid, zero: mag_ff.zero,
                         negp: mag_ff.negp, negq: mag_ff.negq};
      end
   end

   for (genvar s = 1; s <= QUO_W; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[s].valid <= 1'b0;
         end else if (adv) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // saturation, sign and status
   always_comb begin
      logic [QUO_W-1:0] lim_p;
      logic [QUO_W-1:0] lim_q;
      logic             sat_p;
      logic             sat_q;
      lim_p = side_ff[QUO_W].negp ? QUO_W'(33'h0_8000_0000) : QUO_W'(33'h0_7FFF_FFFF);
      lim_q = side_ff[QUO_W].negq ? QUO_W'(33'h0_8000_0000) : QUO_W'(33'h0_7FFF_FFFF);
      sat_p = ovf_p || (quo_p > lim_p);
      sat_q = ovf_q || (quo_q > lim_q);
      if (sat_p) begin
         rsp_data_in.quot_re = side_ff[QUO_W].negp ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         rsp_data_in.quot_re = side_ff[QUO_W].negp ? -$signed(quo_p[DATA_W-1:0])
                                                   : $signed(quo_p[DATA_W-1:0]);
      end
      if (sat_q) begin
         rsp_data_in.quot_im = side_ff[QUO_W].negq ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         rsp_data_in.quot_im = side_ff[QUO_W].negq ? -$signed(quo_q[DATA_W-1:0])
                                                   : $signed(quo_q[DATA_W-1:0]);
      end
      rsp_data_in.status = (sat_p || sat_q) ? STAT_SAT : STAT_OK;
      if (side_ff[QUO_W].zero) begin
         rsp_data_in.quot_re = '0;
         rsp_data_in.quot_im = '0;
         rsp_data_in.status  = STAT_ZERO;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= side_ff[QUO_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // zero divisor always comes out as a zero quotient
   a_zero_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_ZERO) |->
         (rsp_data.quot_re == '0) && (rsp_data.quot_im == '0))
      else $error("zero divisor result not cleared");

   // a saturated result carries at least one bound value
   a_sat_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_SAT) |->
         (rsp_data.quot_re == 32'sh7FFF_FFFF) || (rsp_data.quot_re == 32'sh8000_0000) ||
         (rsp_data.quot_im == 32'sh7FFF_FFFF) || (rsp_data.quot_im == 32'sh8000_0000))
      else $error("saturated status without a bound value");

   // a frozen pipeline keeps its entry stage
   a_freeze : assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(rat_ff[0].valid))
      else $error("entry stage changed while stalled");

   // the last divider stage feeds the output whenever the output is free
   a_advance : assert property (@(posedge clock) disable iff (reset)
      !req_stall && side_ff[QUO_W].valid |=> rsp_valid)
      else $error("result lost between divider and output");

endmodule

`default_nettype wire
